// ===== rtl/rsst_pkg.sv =====
`default_nettype none

package rsst_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int POS_W        = 10;
    localparam int CNT_W        = 11;
    localparam int NODE_W       = 11;
    localparam int NODE_SLOTS   = 2048;
    localparam int STACK_DEPTH  = 11;
    localparam int SP_W         = 4;
    localparam int SIDX_W       = 4;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // One tree node in heap order together with the element span it covers.
    typedef struct packed {
        logic [NODE_W-1:0] num;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  last;
    } node_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rsst_stack.sv =====
`default_nettype none

// Holds the right-hand nodes still to be visited by the query walk.
module rsst_stack (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire rsst_pkg::stack_ctl_t   ctl,
    input  wire rsst_pkg::node_t        push_node,
    output rsst_pkg::node_t             top_node,
    output logic                        empty
);

    rsst_pkg::node_t             entries_reg [rsst_pkg::STACK_DEPTH];
    logic [rsst_pkg::SP_W-1:0]   sp_reg;
    logic [rsst_pkg::SP_W-1:0]   sp_next;
    logic [rsst_pkg::SIDX_W-1:0] top_idx;

    assign top_idx  = sp_reg[rsst_pkg::SIDX_W-1:0] - 1'b1;
    assign top_node = entries_reg[top_idx];
    assign empty    = (sp_reg == '0);

    always_comb
    begin
        sp_next = sp_reg;
        if (ctl.push)
        begin
            sp_next = sp_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            sp_next = sp_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            entries_reg[sp_reg[rsst_pkg::SIDX_W-1:0]] <= push_node;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/range_sum_segment_tree.sv =====
// Update: one cycle per tree level on the way down to the leaf, then one cycle per level on
// the way back up (sibling read and parent write share a cycle).
// Query: one cycle per visited node, then the sum is delivered; the node memory has a
// single read port. One item is in work at a time.
// After reset a clearing pass writes zero to all 2048 node entries, one per cycle, and no
// item is accepted until it ends; used_count resets to 1024.
`default_nettype none

module range_sum_segment_tree (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // index[9:0], new_value[41:10], left_bound[51:42], right_bound[61:52], zeros above
    input  wire  [63:0] s_axis_tdata,
    // kind[0]
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // range_sum[31:0]
    output logic [31:0] m_axis_tdata,
    input  wire         cfg_we,
    input  wire  [10:0] cfg_wdata
);

    localparam int POS_W  = rsst_pkg::POS_W;
    localparam int NODE_W = rsst_pkg::NODE_W;
    localparam int VAL_W  = rsst_pkg::VALUE_BITS;
    localparam int CNT_W  = rsst_pkg::CNT_W;

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_UPD_DOWN = 7'b0000100,
        ST_UPD_UP   = 7'b0001000,
        ST_QRY_WALK = 7'b0010000,
        ST_QRY_LAST = 7'b0100000,
        ST_QRY_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  used_count_reg;
    logic [NODE_W-1:0] clr_addr_reg, clr_addr_next;
    rsst_pkg::node_t   node_reg, node_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_data_reg, out_data_next;

    // Node memory: one write and one read port, read data registered.
    logic [VAL_W-1:0]  mem [rsst_pkg::NODE_SLOTS];
    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [NODE_W-1:0] mem_raddr;
    logic [VAL_W-1:0]  mem_rdata_reg;

    rsst_pkg::stack_ctl_t stk_ctl;
    rsst_pkg::node_t      stk_push;
    rsst_pkg::node_t      stk_top;
    logic                 stk_empty;

    logic [CNT_W-1:0]  live_n;
    logic [CNT_W-1:0]  live_nm1;
    logic [POS_W-1:0]  last_pos;
    logic [POS_W-1:0]  in_index;
    logic [VAL_W-1:0]  in_value;
    logic [POS_W-1:0]  in_lo;
    logic [POS_W-1:0]  in_hi;
    logic              in_accept;
    logic [POS_W:0]    span_sum;
    logic [POS_W-1:0]  mid;
    logic              disjoint;
    logic              covered;
    logic [VAL_W-1:0]  up_sum;
    logic [NODE_W-1:0] parent;
    rsst_pkg::node_t   left_child;
    rsst_pkg::node_t   right_child;

    assign in_index = s_axis_tdata[9:0];
    assign in_value = s_axis_tdata[41:10];
    assign in_lo    = s_axis_tdata[51:42];
    assign in_hi    = s_axis_tdata[61:52];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A count of zero behaves as one, anything above the store size as the store size.
    always_comb
    begin
        if (used_count_reg == '0)
        begin
            live_n = CNT_W'(1);
        end
        else if (used_count_reg > CNT_W'(rsst_pkg::MAX_ELEMENTS))
        begin
            live_n = CNT_W'(rsst_pkg::MAX_ELEMENTS);
        end
        else
        begin
            live_n = used_count_reg;
        end
    end

    assign live_nm1 = live_n - 1'b1;
    assign last_pos = live_nm1[POS_W-1:0];

    assign span_sum = {1'b0, node_reg.first} + {1'b0, node_reg.last};
    assign mid      = span_sum[POS_W:1];
    assign disjoint = (lo_reg > node_reg.last) || (hi_reg < node_reg.first);
    assign covered  = (lo_reg <= node_reg.first) && (node_reg.last <= hi_reg);
    assign up_sum   = acc_reg + mem_rdata_reg;
    assign parent   = {1'b0, node_reg.num[NODE_W-1:1]};

    assign left_child.num    = {node_reg.num[NODE_W-2:0], 1'b0};
    assign left_child.first  = node_reg.first;
    assign left_child.last   = mid;
    assign right_child.num   = {node_reg.num[NODE_W-2:0], 1'b1};
    assign right_child.first = mid + 1'b1;
    assign right_child.last  = node_reg.last;

    assign stk_push = right_child;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        node_next      = node_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg.num;
        mem_wdata      = acc_reg;
        mem_re         = 1'b0;
        mem_raddr      = node_reg.num;
        stk_ctl        = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == NODE_W'(rsst_pkg::NODE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    node_next.num   = NODE_W'(1);
                    node_next.first = '0;
                    node_next.last  = last_pos;
                    pos_next        = in_index;
                    val_next        = in_value;
                    acc_next        = '0;
                    lo_next         = in_lo;
                    hi_next         = (in_hi > last_pos) ? last_pos : in_hi;
                    if (s_axis_tuser[0] == rsst_pkg::KIND_UPDATE)
                    begin
                        if ({1'b0, in_index} < live_n)
                        begin
                            state_next = ST_UPD_DOWN;
                        end
                    end
                    else if ((in_lo <= in_hi) && ({1'b0, in_lo} < live_n))
                    begin
                        state_next = ST_QRY_WALK;
                    end
                    else
                    begin
                        state_next = ST_QRY_OUT;
                    end
                end
            end

            ST_UPD_DOWN:
            begin
                if (node_reg.first == node_reg.last)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = val_reg;
                    acc_next  = val_reg;
                    if (node_reg.num == NODE_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = node_reg.num ^ NODE_W'(1);
                        state_next = ST_UPD_UP;
                    end
                end
                else if (pos_reg <= mid)
                begin
                    node_next = left_child;
                end
                else
                begin
                    node_next = right_child;
                end
            end

            ST_UPD_UP:
            begin
                // The sibling just read is off the update path, so it never meets a write.
                mem_we        = 1'b1;
                mem_waddr     = parent;
                mem_wdata     = up_sum;
                acc_next      = up_sum;
                node_next.num = parent;
                if (parent == NODE_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent ^ NODE_W'(1);
                end
            end

            ST_QRY_WALK:
            begin
                if (rd_pend_reg)
                begin
                    acc_next = up_sum;
                end
                if (disjoint || covered)
                begin
                    if (covered)
                    begin
                        mem_re       = 1'b1;
                        rd_pend_next = 1'b1;
                    end
                    if (stk_empty)
                    begin
                        state_next = ST_QRY_LAST;
                    end
                    else
                    begin
                        stk_ctl.pop = 1'b1;
                        node_next   = stk_top;
                    end
                end
                else
                begin
                    stk_ctl.push = 1'b1;
                    node_next    = left_child;
                end
            end

            ST_QRY_LAST:
            begin
                if (rd_pend_reg)
                begin
                    acc_next = up_sum;
                end
                state_next = ST_QRY_OUT;
            end

            ST_QRY_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rsst_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stk_ctl),
        .push_node (stk_push),
        .top_node  (stk_top),
        .empty     (stk_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            used_count_reg <= CNT_W'(rsst_pkg::MAX_ELEMENTS);
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                used_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        acc_reg      <= acc_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // The walk always leaves the node stack empty behind it.
    a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> stk_empty)
        else $error("node stack not empty while idle");

    // A query only reads the node memory.
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_QRY_WALK) || (state_reg == ST_QRY_LAST)) |-> !mem_we)
        else $error("node memory written during a query");

    // A result appears only from the delivery state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_QRY_OUT))
        else $error("result raised outside delivery");

    // The span of the node in work is never inverted.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPD_DOWN) || (state_reg == ST_QRY_WALK))
            |-> (node_reg.first <= node_reg.last))
        else $error("node span inverted");

endmodule

`default_nettype wire

// ===== verif/tb_range_sum_segment_tree.sv =====
`default_nettype none

module tb_range_sum_segment_tree;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned ITEM_TARGET   = 1750;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned HOLD_CYCLES   = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // index[9:0], new_value[41:10], left_bound[51:42], right_bound[61:52], zeros above
    logic [63:0] s_axis_tdata = '0;
    // kind[0]
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // range_sum[31:0]
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;

    // Mirror of the block's node store and its element count register.
    logic [31:0] tree_mirror [rsst_pkg::NODE_SLOTS];
    logic [10:0] count_reg = 11'd1024;

    logic [31:0] sums_due [$];

    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned rx_wait = 0;
    int unsigned rx_hold = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned items_done = 0;
    int unsigned n_updates = 0;
    int unsigned n_ignored = 0;
    int unsigned n_queries = 0;
    int unsigned n_settings = 0;
    int unsigned sums_checked = 0;

    range_sum_segment_tree u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("range_sum_segment_tree verification failed");
            $finish;
        end
    end

    function automatic int unsigned active_elems();
        int unsigned c;
        c = count_reg;
        if (c == 0)
            c = 1;
        if (c > rsst_pkg::MAX_ELEMENTS)
            c = rsst_pkg::MAX_ELEMENTS;
        return c;
    endfunction

    // Nodes past the end of the store read as zero and swallow writes.
    function automatic logic [31:0] mirror_read(input int unsigned t);
        return (t < rsst_pkg::NODE_SLOTS) ? tree_mirror[t] : 32'd0;
    endfunction

    function automatic void mirror_write(input int unsigned t, input logic [31:0] v);
        if (t < rsst_pkg::NODE_SLOTS)
            tree_mirror[t] = v;
    endfunction

    function automatic void apply_point_write(input logic [9:0] pos, input logic [31:0] value);
        int unsigned n;
        int unsigned node;
        int unsigned first;
        int unsigned last;
        int unsigned mid;
        int unsigned path [$];
        n = active_elems();
        if (pos >= n)
            return;
        node = 1;
        first = 0;
        last = n - 1;
        while (first != last)
        begin
            path.push_back(node);
            mid = (first + last) / 2;
            if (pos <= mid)
            begin
                node = 2 * node;
                last = mid;
            end
            else
            begin
                node = 2 * node + 1;
                first = mid + 1;
            end
        end
        mirror_write(node, value);
        while (path.size() != 0)
        begin
            node = path.pop_back();
            mirror_write(node, mirror_read(2 * node) + mirror_read(2 * node + 1));
        end
    endfunction

    function automatic logic [31:0] range_total(input logic [9:0] lo, input logic [9:0] hi);
        int unsigned     n;
        int unsigned     last_pos;
        int unsigned     mid;
        logic [31:0]     acc;
        rsst_pkg::node_t cur;
        rsst_pkg::node_t child;
        rsst_pkg::node_t pending [$];
        n = active_elems();
        acc = '0;
        if (lo > hi || lo >= n)
            return acc;
        last_pos = (hi > n - 1) ? n - 1 : hi;
        cur.num = 11'd1;
        cur.first = 10'd0;
        cur.last = 10'(n - 1);
        pending.push_back(cur);
        // Walk the tree with an explicit stack; the order of the partial sums is immaterial.
        while (pending.size() != 0)
        begin
            cur = pending.pop_back();
            if (lo > cur.last || last_pos < cur.first)
                continue;
            if (lo <= cur.first && cur.last <= last_pos)
                acc += mirror_read(cur.num);
            else
            begin
                mid = (32'(cur.first) + 32'(cur.last)) / 2;
                child.num = 11'(2 * cur.num);
                child.first = cur.first;
                child.last = 10'(mid);
                pending.push_back(child);
                child.num = 11'(2 * cur.num + 1);
                child.first = 10'(mid + 1);
                child.last = cur.last;
                pending.push_back(child);
            end
        end
        return acc;
    endfunction

    // Result side: checks each sum and draws a stall before the next one.
    always @(posedge clk)
    begin : result_check
        logic        next_ready;
        logic [31:0] want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (sums_due.size() == 0)
            begin
                error_count++;
                $display("%0t: range_sum %h arrived with no query outstanding",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = sums_due.pop_front();
                sums_checked++;
                if (want !== m_axis_tdata)
                begin
                    error_count++;
                    $display("%0t: range_sum mismatch: expected %h, actual %h",
                             $time, want, m_axis_tdata);
                end
            end
            rx_wait = quiet ? 0 : $urandom_range(0, 11);
        end
        if (hold_req)
        begin
            rx_hold = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (rx_hold != 0)
        begin
            rx_hold--;
            next_ready = 1'b0;
        end
        else if (rx_wait != 0)
        begin
            rx_wait--;
            next_ready = 1'b0;
        end
        else
            next_ready = 1'b1;
        m_axis_tready <= next_ready;
    end

    task automatic send_item(input logic kind, input logic [9:0] idx, input logic [31:0] val,
                             input logic [9:0] lo, input logic [9:0] hi);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, hi, lo, val, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == rsst_pkg::KIND_QUERY)
        begin
            sums_due.push_back(range_total(lo, hi));
            n_queries++;
            items_done++;
        end
        else
        begin
            n_updates++;
            if (idx < active_elems())
                items_done++;
            else
                n_ignored++;
            apply_point_write(idx, val);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sums_due.size() != 0)
            @(posedge clk);
        // An update gives no result, so let the last one finish its walk as well.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [10:0] setting);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_reg = setting;
        n_settings++;
    endtask

    task automatic random_op();
        int unsigned n;
        int unsigned pick;
        logic        kind;
        logic [9:0]  idx;
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [9:0]  a;
        logic [9:0]  b;
        logic [31:0] val;
        n = active_elems();
        kind = ($urandom_range(0, 99) < 55) ? rsst_pkg::KIND_QUERY : rsst_pkg::KIND_UPDATE;
        idx = 10'($urandom);
        val = $urandom;
        lo = 10'($urandom);
        hi = 10'($urandom);
        if (kind == rsst_pkg::KIND_UPDATE)
        begin
            if ($urandom_range(0, 9) != 0)
                idx = 10'($urandom_range(0, n - 1));
            case ($urandom_range(0, 11))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0000_0000;
                default: ;
            endcase
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick == 1)
            begin
                lo = 10'($urandom_range(1, 1023));
                hi = 10'($urandom_range(0, lo - 1));
            end
            else if (pick == 2)
            begin
                lo = 10'($urandom_range(0, n - 1));
                hi = 10'($urandom_range(n - 1, 1023));
            end
            else if (pick >= 3)
            begin
                a = 10'($urandom_range(0, n - 1));
                b = 10'($urandom_range(0, n - 1));
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        end
        send_item(kind, idx, val, lo, hi);
    endtask

    task automatic test_directed_full_tree();
        send_item(rsst_pkg::KIND_UPDATE, 10'd0, 32'h7FFF_FFFF, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_UPDATE, 10'd1023, 32'h8000_0000, 10'd1023, 10'd1023);
        send_item(rsst_pkg::KIND_UPDATE, 10'd511, 32'hFFFF_FFFF, 10'h2AA, 10'h155);
        send_item(rsst_pkg::KIND_UPDATE, 10'd512, 32'h0000_0001, 10'h155, 10'h2AA);
        send_item(rsst_pkg::KIND_QUERY, 10'h3FF, 32'hFFFF_FFFF, 10'd0, 10'd1023);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd1023, 10'd1023);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd511, 10'd512);
        // Empty range: the first bound lies past the last.
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd600, 10'd5);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd511);
        send_item(rsst_pkg::KIND_UPDATE, 10'd0, 32'd0, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd1023);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd1023, 10'd0);
        drain_results();
    endtask

    task automatic test_random_full_tree();
        for (int unsigned i = 0; i < 300; i++)
        begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            random_op();
        end
        quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_backpressure();
        // The receiver stalls for a long stretch while queries keep coming, so the
        // block fills up and holds its input off.
        quiet = 1'b1;
        hold_req = 1'b1;
        repeat (8)
            send_item(rsst_pkg::KIND_QUERY, 10'($urandom), $urandom,
                      10'($urandom_range(0, 511)), 10'($urandom_range(512, 1023)));
        drain_results();
        repeat (24) random_op();
        quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_count_extremes();
        // A count of zero behaves as a single element.
        write_count(11'd0);
        send_item(rsst_pkg::KIND_UPDATE, 10'd0, 32'h1234_5678, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_UPDATE, 10'd1, 32'hDEAD_BEEF, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_UPDATE, 10'd1023, 32'hCAFE_F00D, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd1023);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd1, 10'd1);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd5, 10'd2);
        drain_results();
        // The largest setting clamps to the full tree; the stale sums are read under
        // the new shape without any reload.
        write_count(11'd2047);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd1023);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd5, 10'd900);
        send_item(rsst_pkg::KIND_UPDATE, 10'd700, 32'hFFFF_FFFB, 10'd0, 10'd0);
        send_item(rsst_pkg::KIND_QUERY, 10'd0, 32'd0, 10'd0, 10'd1023);
        drain_results();
    endtask

    task automatic test_random_segments();
        logic [10:0] setting;
        int unsigned pick;
        int unsigned load_count;
        while (items_done < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                setting = 11'($urandom_range(1, 48));
            else if (pick < 8)
                setting = 11'($urandom_range(49, 200));
            else if (pick == 8)
                setting = 11'($urandom_range(201, 400));
            else
                setting = 11'($urandom_range(0, 2047));
            drain_results();
            write_count(setting);
            quiet = ($urandom_range(0, 3) == 0);
            // Most settings get a full reload; the rest keep the old sums on purpose.
            if (pick != 9)
            begin
                load_count = active_elems();
                for (int unsigned i = 0; i < load_count; i++)
                    send_item(rsst_pkg::KIND_UPDATE, 10'(i), $urandom, 10'($urandom),
                              10'($urandom));
            end
            repeat ($urandom_range(30, 90)) random_op();
        end
        quiet = 1'b0;
        drain_results();
    endtask

    initial
    begin : test_sequence
        foreach (tree_mirror[i])
            tree_mirror[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_full_tree();
        test_random_full_tree();
        test_backpressure();
        test_count_extremes();
        test_random_segments();
        $display("Covered %0d updates (%0d past the end) and %0d range queries",
                 n_updates, n_ignored, n_queries);
        $display("over %0d count settings; %0d sums compared, %0d mismatches, %0d cycles.",
                 n_settings, sums_checked, error_count, cycle_count);
        if (error_count == 0 && sums_due.size() == 0)
            $display("range_sum_segment_tree verification clean");
        else
            $display("range_sum_segment_tree verification failed");
        $finish;
    end

endmodule

`default_nettype wire
